@@ sv/rrp_pkg.sv @@
// Shared types and constants for the relative rigid pose unit.
`default_nettype none
package rrp_pkg;

    localparam int QUAT_W  = 16;
    localparam int POS_W   = 24;
    localparam int ROT_W   = 18;
    localparam int TRANS_W = 26;
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = ROT_W + DIFF_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int PP_W    = 2 * QUAT_W;
    localparam int NUM_W   = PP_W + 4;
    localparam int NRM_W   = PP_W + 1;
    localparam int QUO_W   = 18;
    localparam int DIV_STEPS = 17;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 240;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [ROT_W-1:0] ROT_ONE = 18'sd65536;
    localparam logic [ACC_W-1:0] TRANS_POS_MAX = ACC_W'((64'd1 << (TRANS_W - 1)) - 64'd1);
    localparam logic [ACC_W-1:0] TRANS_NEG_MAX = ACC_W'(64'd1 << (TRANS_W - 1));

    // Input item as held in the queue
    typedef struct packed {
        logic                     kind;
        logic signed [QUAT_W-1:0] qw;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
    } item_t;

    // Queue status toward the top level
    typedef struct packed {
        logic full;
        logic empty;
    } front_stat_t;

    // Back end status toward the top level
    typedef struct packed {
        logic busy;
        logic result_pending;
    } back_stat_t;

endpackage
`default_nettype wire

@@ sv/rrp_front.sv @@
// Front end: accepts pose items, decodes them and queues them for the back end.
`default_nettype none
module rrp_front
    import rrp_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic                      item_valid,
    input  wire logic                 item_pop,
    output item_t                     item,
    output front_stat_t               fstat
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    item_t              q_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    item_t              in_item;
    logic               push;

    // Unpack the transfer
    always_comb
    begin
        in_item.kind = s_tuser;
        in_item.qw   = s_tdata[15:0];
        in_item.qx   = s_tdata[31:16];
        in_item.qy   = s_tdata[47:32];
        in_item.qz   = s_tdata[63:48];
        in_item.px   = s_tdata[87:64];
        in_item.py   = s_tdata[111:88];
        in_item.pz   = s_tdata[135:112];
    end

    assign s_tready   = (cnt_reg != CNT_W'(FIFO_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != '0);
    assign item       = q_reg[rd_ptr_reg];
    assign fstat.full  = !s_tready;
    assign fstat.empty = !item_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !item_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && item_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

@@ sv/rrp_back.sv @@
// Back end: quaternion to matrix conversion, reference update and relative pose.
`default_nettype none
module rrp_back
    import rrp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_pop,
    input  wire item_t                 item,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output back_stat_t                 bstat
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PROD = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_MAC  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    item_t                     cur_reg;
    logic [4:0]                cnt_reg;
    logic [3:0]                ent_reg;
    logic signed [PP_W-1:0]    pp_reg [10];
    logic signed [DIFF_W-1:0]  d_reg [3];
    logic signed [ROT_W-1:0]   rot_reg [9];
    logic signed [ROT_W-1:0]   ref_rot_reg [9];
    logic signed [POS_W-1:0]   ref_pos_reg [3];
    logic signed [ROT_W-1:0]   rout_reg [9];
    logic signed [TRANS_W-1:0] tout_reg [3];

    // shared multiplier
    logic signed [ROT_W-1:0]   mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p_reg;

    // divider
    logic [NRM_W-1:0]          n_reg;
    logic [NRM_W-1:0]          r_reg;
    logic [QUO_W-1:0]          t_reg;
    logic                      neg_reg;

    // accumulate pipeline
    logic [1:0]                kk_reg, ri_reg, col_reg;
    logic                      iss_reg;
    logic                      s1_v_reg, s2_v_reg;
    logic [1:0]                s1_k_reg, s1_i_reg, s1_c_reg, s2_i_reg, s2_c_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    assign item_pop = (state_reg == ST_IDLE) && item_valid;
    assign m_tvalid = (state_reg == ST_OUT);
    assign bstat.busy = (state_reg != ST_IDLE);
    assign bstat.result_pending = m_tvalid;

    // Pack the result
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            m_tdata[i*ROT_W +: ROT_W] = rout_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            m_tdata[9*ROT_W + i*TRANS_W +: TRANS_W] = tout_reg[i];
        end
    end

    // Quaternion products: squares first, then cross terms
    logic signed [QUAT_W-1:0] pa, pb;
    always_comb
    begin
        case (cnt_reg[3:0])
            4'd0:    begin pa = cur_reg.qw; pb = cur_reg.qw; end
            4'd1:    begin pa = cur_reg.qx; pb = cur_reg.qx; end
            4'd2:    begin pa = cur_reg.qy; pb = cur_reg.qy; end
            4'd3:    begin pa = cur_reg.qz; pb = cur_reg.qz; end
            4'd4:    begin pa = cur_reg.qx; pb = cur_reg.qy; end
            4'd5:    begin pa = cur_reg.qw; pb = cur_reg.qz; end
            4'd6:    begin pa = cur_reg.qx; pb = cur_reg.qz; end
            4'd7:    begin pa = cur_reg.qw; pb = cur_reg.qy; end
            4'd8:    begin pa = cur_reg.qy; pb = cur_reg.qz; end
            default: begin pa = cur_reg.qw; pb = cur_reg.qx; end
        endcase
    end

    // Operand select for the shared multiplier
    logic [3:0] ref_idx, rot_idx;
    assign ref_idx = 4'({kk_reg, 1'b0}) + 4'(kk_reg) + 4'(ri_reg);
    assign rot_idx = 4'({kk_reg, 1'b0}) + 4'(kk_reg) + 4'(col_reg);
    always_comb
    begin
        if (state_reg == ST_MAC)
        begin
            mul_a = ref_rot_reg[ref_idx];
            mul_b = (col_reg == 2'd3) ? d_reg[kk_reg] : DIFF_W'(rot_reg[rot_idx]);
        end
        else
        begin
            mul_a = ROT_W'(pa);
            mul_b = DIFF_W'(pb);
        end
    end

    // Normalizer (registered during the product phase) and numerator of the current entry
    logic signed [NUM_W-1:0] nsum, n_s, num, mag_s;
    logic [NRM_W-1:0]        n_u, mag;
    logic                    n_zero;
    assign nsum = NUM_W'(pp_reg[0]) + NUM_W'(pp_reg[1]) + NUM_W'(pp_reg[2])
                + NUM_W'(pp_reg[3]);
    assign n_u    = n_reg;
    assign n_s    = $signed(NUM_W'(n_reg));
    assign n_zero = (n_u == '0);
    always_comb
    begin
        case (ent_reg)
            4'd0:    num = n_s - ((NUM_W'(pp_reg[2]) + NUM_W'(pp_reg[3])) <<< 1);
            4'd1:    num = (NUM_W'(pp_reg[4]) - NUM_W'(pp_reg[5])) <<< 1;
            4'd2:    num = (NUM_W'(pp_reg[6]) + NUM_W'(pp_reg[7])) <<< 1;
            4'd3:    num = (NUM_W'(pp_reg[4]) + NUM_W'(pp_reg[5])) <<< 1;
            4'd4:    num = n_s - ((NUM_W'(pp_reg[1]) + NUM_W'(pp_reg[3])) <<< 1);
            4'd5:    num = (NUM_W'(pp_reg[8]) - NUM_W'(pp_reg[9])) <<< 1;
            4'd6:    num = (NUM_W'(pp_reg[6]) - NUM_W'(pp_reg[7])) <<< 1;
            4'd7:    num = (NUM_W'(pp_reg[8]) + NUM_W'(pp_reg[9])) <<< 1;
            default: num = n_s - ((NUM_W'(pp_reg[1]) + NUM_W'(pp_reg[2])) <<< 1);
        endcase
        mag_s = (num < 0) ? -num : num;
        mag   = mag_s[NRM_W-1:0];
    end

    // One restoring division step
    logic [NRM_W:0]   r2;
    logic             ge;
    logic [NRM_W-1:0] r_new;
    logic [QUO_W-1:0] t_step;
    logic [QUO_W:0]   q_inc;
    logic signed [ROT_W-1:0] q_mag, rot_val;
    always_comb
    begin
        r2     = {r_reg, 1'b0};
        ge     = (r2 >= {1'b0, n_u});
        r_new  = ge ? NRM_W'(r2 - {1'b0, n_u}) : r2[NRM_W-1:0];
        t_step = {t_reg[QUO_W-2:0], ge};
        q_inc  = {1'b0, t_step} + 1'b1;
        q_mag  = q_inc[QUO_W:1];
        if (n_zero)
        begin
            rot_val = (ent_reg == 4'd0 || ent_reg == 4'd4 || ent_reg == 4'd8) ? ROT_ONE : '0;
        end
        else
        begin
            rot_val = neg_reg ? -q_mag : q_mag;
        end
    end

    // Round and saturate a finished dot product
    logic [ACC_W-1:0]       acc_mag, rnd;
    logic                   acc_neg;
    logic [ACC_W-1:0]       lim_r, lim_t;
    logic signed [ROT_W-1:0]   fin_rot;
    logic signed [TRANS_W-1:0] fin_trans;
    always_comb
    begin
        acc_neg = acc_reg[ACC_W-1];
        acc_mag = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        rnd     = (acc_mag + ACC_W'(1 << 15)) >> 16;
        lim_r   = (rnd > ACC_W'(65536)) ? ACC_W'(65536) : rnd;
        if (acc_neg)
        begin
            lim_t = (rnd > TRANS_NEG_MAX) ? TRANS_NEG_MAX : rnd;
        end
        else
        begin
            lim_t = (rnd > TRANS_POS_MAX) ? TRANS_POS_MAX : rnd;
        end
        fin_rot   = acc_neg ? -ROT_W'(lim_r) : ROT_W'(lim_r);
        fin_trans = acc_neg ? -TRANS_W'(lim_t) : TRANS_W'(lim_t);
    end

    logic mac_done;
    assign mac_done = !iss_reg && !s1_v_reg && !s2_v_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (item_valid) state_next = ST_PROD;
            ST_PROD: if (cnt_reg == 5'd10) state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 5'(DIV_STEPS) && ent_reg == 4'd8)
                begin
                    state_next = cur_reg.kind ? ST_MAC : ST_IDLE;
                end
            end
            ST_MAC:  if (mac_done) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ent_reg   <= '0;
            iss_reg   <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                ref_rot_reg[i] <= (i % 4 == 0) ? ROT_ONE : '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                ref_pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                end
                ST_PROD:
                begin
                    cnt_reg <= (cnt_reg == 5'd10) ? '0 : cnt_reg + 1'b1;
                    ent_reg <= '0;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 5'(DIV_STEPS))
                    begin
                        cnt_reg <= '0;
                        ent_reg <= ent_reg + 1'b1;
                        if (ent_reg == 4'd8)
                        begin
                            iss_reg <= cur_reg.kind;
                            if (!cur_reg.kind)
                            begin
                                for (int i = 0; i < 8; i++)
                                begin
                                    ref_rot_reg[i] <= rot_reg[i];
                                end
                                ref_rot_reg[8] <= rot_val;
                                ref_pos_reg[0] <= cur_reg.px;
                                ref_pos_reg[1] <= cur_reg.py;
                                ref_pos_reg[2] <= cur_reg.pz;
                            end
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_MAC:
                begin
                    s1_v_reg <= iss_reg;
                    s2_v_reg <= s1_v_reg && (s1_k_reg == 2'd2);
                    if (iss_reg && kk_reg == 2'd2 && ri_reg == 2'd2 && col_reg == 2'd3)
                    begin
                        iss_reg <= 1'b0;
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cur_reg <= item;
                end
            end
            ST_PROD:
            begin
                if (cnt_reg != '0)
                begin
                    pp_reg[4'(cnt_reg - 5'd1)] <= mul_p_reg[PP_W-1:0];
                end
                // squares are complete well before the last product cycle
                n_reg    <= nsum[NRM_W-1:0];
                d_reg[0] <= DIFF_W'(cur_reg.px) - DIFF_W'(ref_pos_reg[0]);
                d_reg[1] <= DIFF_W'(cur_reg.py) - DIFF_W'(ref_pos_reg[1]);
                d_reg[2] <= DIFF_W'(cur_reg.pz) - DIFF_W'(ref_pos_reg[2]);
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    neg_reg <= (num < 0);
                    if (mag >= n_u)
                    begin
                        r_reg <= mag - n_u;
                        t_reg <= QUO_W'(1);
                    end
                    else
                    begin
                        r_reg <= mag;
                        t_reg <= '0;
                    end
                end
                else
                begin
                    r_reg <= r_new;
                    t_reg <= t_step;
                end
                if (cnt_reg == 5'(DIV_STEPS))
                begin
                    rot_reg[ent_reg] <= rot_val;
                end
                kk_reg  <= '0;
                ri_reg  <= '0;
                col_reg <= '0;
            end
            ST_MAC:
            begin
                // issue
                if (iss_reg)
                begin
                    kk_reg <= (kk_reg == 2'd2) ? 2'd0 : kk_reg + 1'b1;
                    if (kk_reg == 2'd2)
                    begin
                        ri_reg <= (ri_reg == 2'd2) ? 2'd0 : ri_reg + 1'b1;
                        if (ri_reg == 2'd2)
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                s1_k_reg <= kk_reg;
                s1_i_reg <= ri_reg;
                s1_c_reg <= col_reg;
                // accumulate
                if (s1_v_reg)
                begin
                    acc_reg  <= ((s1_k_reg == 2'd0) ? '0 : acc_reg) + ACC_W'(mul_p_reg);
                    s2_i_reg <= s1_i_reg;
                    s2_c_reg <= s1_c_reg;
                end
                // finish
                if (s2_v_reg)
                begin
                    if (s2_c_reg == 2'd3)
                    begin
                        tout_reg[s2_i_reg] <= fin_trans;
                    end
                    else
                    begin
                        rout_reg[4'({s2_i_reg, 1'b0}) + 4'(s2_i_reg) + 4'(s2_c_reg)] <= fin_rot;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/relative_rigid_pose_unit.sv @@
// Top level of the relative rigid pose unit.
`default_nettype none
// Each transfer carries a pose (quaternion of any scale plus position). A kind-0
// transfer makes it the reference pose and returns nothing; a kind-1 transfer
// returns the pose relative to the reference: rotation R_ref^T*R in Q2.16 and
// translation R_ref^T*(p - p_ref) in the position format. One item is worked at
// a time by a sequencer around a single shared 18x25 multiplier and a radix-2
// divider: it takes the item from the input queue, forms the quaternion products,
// runs 9 divisions, and for kind 1 forms the dot products and then holds the
// result until it is taken. An input queue (two entries by default) takes
// new items while a result waits to be taken.
module relative_rigid_pose_unit
    import rrp_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // rot_00 .. rot_22 (row-major), trans_x, trans_y, trans_z
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic        item_valid;
    logic        item_pop;
    item_t       item;
    front_stat_t fstat;
    back_stat_t  bstat;

    rrp_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .fstat      (fstat)
    );

    rrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .bstat      (bstat)
    );

`ifndef SYNTH
    // queue is never full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n) !(fstat.full && fstat.empty))
        else $error("queue full and empty together");
    // no item leaves the queue while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !item_pop)
        else $error("item popped while result pending");
    // a result only appears after the back end was busy
    assert property (@(posedge clk) disable iff (!rst_n) $rose(m_tvalid) |-> $past(bstat.busy))
        else $error("result without work");
    // a popped item makes the back end busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n) item_pop |=> bstat.busy)
        else $error("back end idle after pop");
`endif

endmodule
`default_nettype wire
